// ===== design/prefix_varint_decoder_unit_macros.svh =====
// Assertion macros used by the decoder's top-level RTL file.
`ifndef PREFIX_VARINT_DECODER_UNIT_MACROS_SVH
`define PREFIX_VARINT_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pvd_pkg.sv =====
package pvd_pkg;

   // One byte of the encoded stream.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       signed_mode;
      logic       end_of_buffer;
   } req_type;

   // One decoded value.
   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  length;
      logic [1:0]  status;
   } rsp_type;

   // Decoder state between bytes; all zero means no value is in progress.
   typedef struct packed {
      logic [2:0]  bytes_seen;
      logic [2:0]  bytes_needed;
      logic [31:0] value_acc;
      logic        signed_latched;
      logic        bad_prefix;
   } state_type;

   // Result status codes.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_PREFIX = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;

   // Encoded value lengths in bytes.
   localparam logic [2:0] LEN_1 = 3'd1;
   localparam logic [2:0] LEN_2 = 3'd2;
   localparam logic [2:0] LEN_3 = 3'd3;
   localparam logic [2:0] LEN_4 = 3'd4;
   localparam logic [2:0] LEN_5 = 3'd5;

   // Sign-extend a 7, 14, 21 or 28 bit payload according to the value length.
   function automatic logic [31:0] sext_payload(input logic [31:0] acc,
                                                input logic [2:0]  len);
      logic [31:0] result;
      begin
         unique case (len)
            LEN_1:   result = {{25{acc[6]}},  acc[6:0]};
            LEN_2:   result = {{18{acc[13]}}, acc[13:0]};
            LEN_3:   result = {{11{acc[20]}}, acc[20:0]};
            LEN_4:   result = {{4{acc[27]}},  acc[27:0]};
            default: result = acc;
         endcase
         return result;
      end
   endfunction

endpackage

// ===== design/pvd_step.sv =====
module pvd_step
   import pvd_pkg::*;
(
   input  state_type cur_state,
   input  req_type   req,
   output state_type nxt_state,
   output logic      rsp_fire,
   output rsp_type   rsp
);

   state_type upd;

   // Take the byte into the state: decode the prefix on a first byte,
   // otherwise shift it into the accumulator.
   always_comb begin
      upd = cur_state;
      if (cur_state.bytes_seen == 3'd0) begin
         upd.signed_latched = req.signed_mode;
         upd.bad_prefix     = 1'b0;
         upd.bytes_seen     = LEN_1;
         if (!req.data_byte[7]) begin
            upd.bytes_needed = LEN_1;
            upd.value_acc    = {24'd0, req.data_byte};
         end else if (!req.data_byte[6]) begin
            upd.bytes_needed = LEN_2;
            upd.value_acc    = {26'd0, req.data_byte[5:0]};
         end else if (!req.data_byte[5]) begin
            upd.bytes_needed = LEN_3;
            upd.value_acc    = {27'd0, req.data_byte[4:0]};
         end else if (!req.data_byte[4]) begin
            upd.bytes_needed = LEN_4;
            upd.value_acc    = {28'd0, req.data_byte[3:0]};
         end else begin
            upd.bytes_needed = LEN_5;
            upd.value_acc    = 32'd0;
            upd.bad_prefix   = req.data_byte[3];
         end
      end else begin
         upd.value_acc  = {cur_state.value_acc[23:0], req.data_byte};
         upd.bytes_seen = cur_state.bytes_seen + 3'd1;
      end
   end

   // Finish the value, cut it short at the buffer end, or keep collecting.
   always_comb begin
      nxt_state = upd;
      rsp_fire  = 1'b0;
      rsp       = '0;
      if (upd.bytes_seen >= upd.bytes_needed) begin
         rsp_fire   = 1'b1;
         rsp.length = upd.bytes_needed;
         rsp.status = STATUS_OK;
         if (upd.bytes_needed == LEN_5) begin
            if (upd.bad_prefix) begin
               rsp.status = STATUS_BAD_PREFIX;
               rsp.value  = 32'd0;
            end else begin
               rsp.value = upd.value_acc;
            end
         end else if (upd.signed_latched) begin
            rsp.value = sext_payload(upd.value_acc, upd.bytes_needed);
         end else begin
            rsp.value = upd.value_acc;
         end
         nxt_state = '0;
      end else if (req.end_of_buffer) begin
         rsp_fire   = 1'b1;
         rsp.value  = 32'd0;
         rsp.length = upd.bytes_seen;
         rsp.status = STATUS_TRUNCATED;
         nxt_state  = '0;
      end
   end

endmodule

// ===== design/prefix_varint_decoder_unit.sv =====
// Channel    Direction  Handshake              Payload
// request    in         req_valid / req_ready  req_data (req_type)
// response   out        rsp_valid / rsp_ready  rsp_data (rsp_type)
//
// One byte is taken per cycle while req_ready is high; a value's result appears the cycle after its
// last byte, or after a byte flagged as the end of the buffer.
// The only storage is the decoder state and one result register.
// Reset clears the decoder state and empties the result register.
// While a result waits, a byte is taken only in a cycle in which the
// result is being drained, so a stalled response holds the request side.
module prefix_varint_decoder_unit
   import pvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "prefix_varint_decoder_unit_macros.svh"

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      step_fire;
   rsp_type   step_rsp;
   state_type step_state;
   logic      req_take;

   // Decode logic for one byte.
   pvd_step u_step (
      .cur_state (state_ff),
      .req       (req_data),
      .nxt_state (step_state),
      .rsp_fire  (step_fire),
      .rsp       (step_rsp)
   );

   // A byte may enter when the result register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   // Next values of the state and the result register.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         state_in = step_state;
         if (step_fire) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = step_rsp;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A value in progress has never reached its full length.
   `PVD_ASSERT_SAME(a_in_progress, clock, reset, state_ff.bytes_seen != 3'd0, state_ff.bytes_seen < state_ff.bytes_needed, "value in progress already complete")

   // A bad five-byte prefix always reports length five and a zero value.
   `PVD_ASSERT_SAME(a_bad_prefix, clock, reset, rsp_valid && rsp_data.status == STATUS_BAD_PREFIX, rsp_data.length == LEN_5 && rsp_data.value == 32'd0, "bad prefix result malformed")

   // A one-byte value taken while idle yields a result in the next cycle.
   `PVD_ASSERT_NEXT(a_single_byte, clock, reset, req_take && state_ff.bytes_seen == 3'd0 && !req_data.data_byte[7], rsp_valid && rsp_data.length == LEN_1, "one-byte value produced no result")

endmodule
